// ----- design/b64e_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64e_pkg: shared types, constants and the character table for the encoder
// Holds the job record passed from the front end to the back end through the
// job queue, the group phase encoding and the sextet-to-ASCII mapping.
// ============================================================================
package b64e_pkg;

    // Default depth of the job queue between front and back end
    localparam int B64E_QUEUE_DEPTH = 4;

    // Characters per job at most (two data, two padding)
    localparam int B64E_JOB_CHARS = 4;

    // ASCII '=' used for padding
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Bytes already taken in the current group of three
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } b64e_phase_t;

    // One classified input byte: the characters it produces
    typedef struct packed {
        logic [B64E_JOB_CHARS-1:0][5:0] sextet;   // data value per slot
        logic [B64E_JOB_CHARS-1:0]      pad;      // slot is '=' padding
        logic [1:0]                     last_idx; // index of final slot
        logic                           eom;      // job closes a message
    } b64e_job_t;

    // Queue status toward front and back end
    typedef struct packed {
        logic full;
        logic empty;
    } b64e_qstat_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] b64e_sextet_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v < 6'd26) begin
            ch = 7'h41 + {1'b0, v};
        end
        else if (v < 6'd52) begin
            ch = 7'h61 + {1'b0, v - 6'd26};
        end
        else if (v < 6'd62) begin
            ch = 7'h30 + {1'b0, v - 6'd52};
        end
        else if (v == 6'd62) begin
            ch = 7'h2B;
        end
        else begin
            ch = 7'h2F;
        end
        return ch;
    endfunction

endpackage

// ----- design/b64e_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64e_front: byte intake and classification
// Accepts one byte per transfer, tracks the group phase and leftover bits,
// and turns each byte into a job of one to four characters for the queue.
// ============================================================================
module b64e_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          data_byte,
    input  logic                end_of_message,
    input  b64e_pkg::b64e_qstat_t qstat,
    output logic                push,
    output b64e_pkg::b64e_job_t push_job
);
    import b64e_pkg::*;

    b64e_phase_t phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;

    // Intake: take a byte whenever the queue has room
    assign byte_stall = qstat.full;
    assign push       = byte_valid && !qstat.full;

    // Phase and leftover registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            left_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // Classification: characters of this byte, flush on end of message
    always_comb
    begin
        push_job          = '0;
        phase_next        = PH_0;
        left_next         = 4'd0;
        unique case (phase_reg)
            PH_1:
            begin
                push_job.sextet[0] = {left_reg[1:0], data_byte[7:4]};
                if (end_of_message)
                begin
                    push_job.sextet[1] = {data_byte[3:0], 2'b00};
                    push_job.pad[2]    = 1'b1;
                    push_job.last_idx  = 2'd2;
                end
                else
                begin
                    phase_next = PH_2;
                    left_next  = data_byte[3:0];
                end
            end
            PH_2:
            begin
                // group complete: two characters, phase back to zero
                push_job.sextet[0] = {left_reg, data_byte[7:6]};
                push_job.sextet[1] = data_byte[5:0];
                push_job.last_idx  = 2'd1;
            end
            default:
            begin
                push_job.sextet[0] = data_byte[7:2];
                if (end_of_message)
                begin
                    push_job.sextet[1] = {data_byte[1:0], 4'b0000};
                    push_job.pad[2]    = 1'b1;
                    push_job.pad[3]    = 1'b1;
                    push_job.last_idx  = 2'd3;
                end
                else
                begin
                    phase_next = PH_1;
                    left_next  = {2'b00, data_byte[1:0]};
                end
            end
        endcase
        push_job.eom = end_of_message;
    end

endmodule

// ----- design/b64e_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64e_queue: job queue between front and back end
// Small first-in first-out register file of classified jobs; lets the intake
// and the character output stall independently.
// ============================================================================
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64e_pkg::b64e_job_t   push_job,
    input  logic                  pop,
    output b64e_pkg::b64e_job_t   head_job,
    output b64e_pkg::b64e_qstat_t qstat
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_job_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job    = store_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

// ----- design/b64e_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64e_back: character output
// Walks the head job's slots, one character per cycle unless stalled, maps
// sextets to the base64 alphabet and holds the result in the output register.
// ============================================================================
module b64e_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64e_pkg::b64e_job_t   head_job,
    input  b64e_pkg::b64e_qstat_t qstat,
    output logic                  pop,
    output logic                  char_valid,
    input  logic                  char_stall,
    output logic [6:0]            out_char,
    output logic                  last_char
);
    import b64e_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_last;

    // Load a new character when the output register is free or draining
    assign load    = !qstat.empty && (!valid_reg || !char_stall);
    assign at_last = (idx_reg == head_job.last_idx);
    assign pop     = load && at_last;

    // Slot walk and character mapping
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && char_stall;
        char_next  = head_job.pad[idx_reg] ? PAD_CHAR
                                           : b64e_sextet_char(head_job.sextet[idx_reg]);
        last_next  = head_job.eom && at_last;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign last_char  = last_reg;

endmodule

// ----- design/base64_stream_encoder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// base64_stream_encoder: streaming base64 encoder with '=' padding
// Byte intake and classification, job queue, and character output.
// ============================================================================
// One byte enters per byte transfer and leaves as one to four characters of
// the standard alphabet, one character per cycle from the output register
// while char_stall is low and the job queue holds a job. A byte is taken in
// the cycle it arrives as long as the job queue has room; a full group of
// three bytes yields four characters and a last byte two to four.
// Throughput is set by the single output character register; the queue
// (QUEUE_DEPTH jobs) absorbs bursts on either side. last_char marks the
// final character of each message, after which the next byte starts a new
// group. QUEUE_DEPTH must be at least 2.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] out_char,
    output logic       last_char
);
    import b64e_pkg::*;

    b64e_job_t   push_job;
    b64e_job_t   head_job;
    b64e_qstat_t qstat;
    logic        push;
    logic        pop;

    // Front end
    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .qstat          (qstat),
        .push           (push),
        .push_job       (push_job)
    );

    // Job queue
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    // Back end
    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .qstat      (qstat),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .last_char  (last_char)
    );

`ifndef ASSERT_OFF
    // Queue cannot be full and empty at once
    a_qstat_excl : assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("job queue full and empty together");

    // Back end never retires a job from an empty queue
    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job retired from empty queue");

    // Padding only appears in jobs that close a message
    a_pad_eom : assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_job.pad != '0)) |-> push_job.eom)
        else $error("padding in a job without end of message");

    // A closing job always flushes at least two characters
    a_eom_len : assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_job.eom) |-> (push_job.last_idx != 2'd0))
        else $error("end of message job too short");
`endif

endmodule
